>>> design/ipts_pkg.sv
// Shared types and constants for the dotted-quad parser and subnet checker.
`default_nettype none
package ipts_pkg;

    // Octets in one dotted-quad address
    localparam int unsigned OCTET_COUNT = 4;
    // Length of the loopback prefix "127."
    localparam int unsigned PREFIX_LEN  = 4;
    // Dots in a well-formed address
    localparam logic [2:0]  DOTS_OK     = 3'd3;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Parse status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DOTS    = 2'd2;

    // String kinds
    localparam logic [1:0] MODE_ADDR0 = 2'd0;
    localparam logic [1:0] MODE_ADDR1 = 2'd1;
    localparam logic [1:0] MODE_MASK  = 2'd2;

    // One request: a character of the current string
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] mode;
        logic       last;
    } req_item_t;

    // One result: parsed string and optional verdict
    typedef struct packed {
        logic [31:0] parsed_address;
        logic [15:0] parsed_port;
        logic [1:0]  status;
        logic        verdict_valid;
        logic        same_subnet;
    } rsp_item_t;

    // Summary of a string as it stands after the current character
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [1:0]  status;
        logic        loopback;
    } parse_sum_t;

    // Expected character of the loopback prefix at a position
    function automatic logic [7:0] loop_prefix_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = CH_ONE;
            2'd1:    c = CH_TWO;
            2'd2:    c = CH_SEVEN;
            default: c = CH_DOT;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/ipts_char_parse.sv
// Per-string character parser: octets, dots, port and loopback prefix.
`default_nettype none
module ipts_char_parse (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               last,
    input  wire logic [7:0]         ch,
    output ipts_pkg::parse_sum_t    sum
);
    import ipts_pkg::*;

    typedef enum logic [1:0] {
        PH_OCTETS,
        PH_PORT,
        PH_STOP,
        PH_INVALID
    } phase_t;

    logic [OCTET_COUNT-1:0][7:0] acc_reg, acc_next;
    logic [2:0]                  pos_reg, pos_next;
    logic [2:0]                  dots_reg, dots_next;
    logic [15:0]                 port_reg, port_next;
    phase_t                      phase_reg, phase_next;
    logic [2:0]                  count_reg, count_next;
    logic                        prefix_reg, prefix_next;

    logic       is_digit;
    logic [3:0] digit;
    logic       first;
    logic [2:0] pos_inc;
    logic [7:0] cur_acc;
    logic [7:0] acc_times_ten;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign first    = (count_reg == 3'd0);
    assign pos_inc  = (pos_reg < 3'd7) ? pos_reg + 3'd1 : pos_reg;
    assign cur_acc  = acc_reg[pos_reg[1:0]];
    // x*10 = x*8 + x*2, modulo 256
    assign acc_times_ten = {cur_acc[4:0], 3'b000} + {cur_acc[6:0], 1'b0};

    // Next state for one character
    always_comb
    begin
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        dots_next   = dots_reg;
        port_next   = port_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        prefix_next = prefix_reg;

        // loopback prefix check over the first four characters
        if ((phase_reg == PH_OCTETS || phase_reg == PH_PORT) &&
            (count_reg < 3'(PREFIX_LEN)))
        begin
            if (ch != loop_prefix_char(count_reg[1:0]))
            begin
                prefix_next = 1'b0;
            end
            count_next = count_reg + 3'd1;
        end

        unique case (phase_reg)
            PH_OCTETS:
            begin
                if (first && !is_digit)
                begin
                    phase_next = PH_INVALID;
                end
                else if (is_digit)
                begin
                    if (pos_reg >= 3'(OCTET_COUNT))
                    begin
                        phase_next = PH_INVALID;
                    end
                    else
                    begin
                        acc_next[pos_reg[1:0]] = acc_times_ten + 8'(digit);
                    end
                end
                else if (ch == CH_DOT)
                begin
                    pos_next = pos_inc;
                    if (dots_reg < 3'd7)
                    begin
                        dots_next = dots_reg + 3'd1;
                    end
                    // write past the last octet is dropped
                    if (pos_inc < 3'(OCTET_COUNT))
                    begin
                        acc_next[pos_inc[1:0]] = 8'd0;
                    end
                end
                else if (ch == CH_COLON)
                begin
                    phase_next = PH_PORT;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_PORT:
            begin
                if (is_digit)
                begin
                    port_next = {port_reg[12:0], 3'b000} + {port_reg[14:0], 1'b0}
                              + 16'(digit);
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Summary after this character
    always_comb
    begin
        sum.addr     = {acc_next[0], acc_next[1], acc_next[2], acc_next[3]};
        sum.port     = port_next;
        if (phase_next == PH_INVALID)
        begin
            sum.status = ST_INVALID;
        end
        else if (dots_next != DOTS_OK)
        begin
            sum.status = ST_DOTS;
        end
        else
        begin
            sum.status = ST_OK;
        end
        sum.loopback = prefix_next && (count_next >= 3'(PREFIX_LEN));
    end

    // String state; a new string starts after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pos_reg    <= '0;
            dots_reg   <= '0;
            port_reg   <= '0;
            phase_reg  <= PH_OCTETS;
            count_reg  <= '0;
            prefix_reg <= 1'b1;
        end
        else if (step)
        begin
            if (last)
            begin
                acc_reg    <= '0;
                pos_reg    <= '0;
                dots_reg   <= '0;
                port_reg   <= '0;
                phase_reg  <= PH_OCTETS;
                count_reg  <= '0;
                prefix_reg <= 1'b1;
            end
            else
            begin
                acc_reg    <= acc_next;
                pos_reg    <= pos_next;
                dots_reg   <= dots_next;
                port_reg   <= port_next;
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                prefix_reg <= prefix_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/ipts_verdict.sv
// Saved addresses, loopback/failure flags and the masked subnet compare.
`default_nettype none
module ipts_verdict (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               done,
    input  wire logic [1:0]         mode,
    input  wire ipts_pkg::parse_sum_t sum,
    output logic                    verdict_valid,
    output logic                    same_subnet
);
    import ipts_pkg::*;

    logic [31:0] addr0_reg;
    logic [31:0] addr1_reg;
    logic        loop_reg, loop_next;
    logic        fail_reg, fail_next;
    logic        str_fail;
    logic        masked_eq;

    assign str_fail  = (sum.status != ST_OK);
    assign masked_eq = ((addr0_reg & sum.addr) == (addr1_reg & sum.addr));

    // Verdict and flag update for a finished string
    always_comb
    begin
        verdict_valid = 1'b0;
        same_subnet   = 1'b0;
        loop_next     = loop_reg;
        fail_next     = fail_reg;
        unique case (mode)
            MODE_ADDR0:
            begin
                loop_next = sum.loopback;
                fail_next = str_fail;
            end
            MODE_ADDR1:
            begin
                loop_next = loop_reg | sum.loopback;
                fail_next = fail_reg | str_fail;
            end
            MODE_MASK:
            begin
                verdict_valid = 1'b1;
                same_subnet   = loop_reg || (!fail_reg && !str_fail && masked_eq);
                loop_next     = 1'b0;
                fail_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr0_reg <= '0;
            addr1_reg <= '0;
            loop_reg  <= 1'b0;
            fail_reg  <= 1'b0;
        end
        else if (done)
        begin
            loop_reg <= loop_next;
            fail_reg <= fail_next;
            if (mode == MODE_ADDR0)
            begin
                addr0_reg <= sum.addr;
            end
            if (mode == MODE_ADDR1)
            begin
                addr1_reg <= sum.addr;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/ipv4_text_subnet_match.sv
// A request is registered in s1_item_reg; the result of a string's last character is registered in out_item_reg.
// Throughput: one character per cycle; the parse of a character is one registered pass.
// A waiting result holds back only a string's last character; other characters keep flowing.
// Reset clears all valids, the per-string parse state, saved addresses and flags
// at once; no clearing pass is needed.
`default_nettype none
module ipv4_text_subnet_match (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire ipts_pkg::req_item_t   req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output ipts_pkg::rsp_item_t        rsp
);
    import ipts_pkg::*;

    logic       s1_valid_reg;
    req_item_t  s1_item_reg;
    logic       out_valid_reg;
    rsp_item_t  out_item_reg;

    logic       out_free;
    logic       s1_step;
    logic       s1_done;
    logic       req_fire;
    parse_sum_t sum;
    logic       verdict_valid;
    logic       same_subnet;

    // Handshake control
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign s1_step   = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign s1_done   = s1_step && s1_item_reg.last;
    assign req_stall = s1_valid_reg && !s1_step;
    assign req_fire  = req_valid && !req_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    ipts_char_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_step),
        .last  (s1_item_reg.last),
        .ch    (s1_item_reg.ch),
        .sum   (sum)
    );

    ipts_verdict u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .done          (s1_done),
        .mode          (s1_item_reg.mode),
        .sum           (sum),
        .verdict_valid (verdict_valid),
        .same_subnet   (same_subnet)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_done;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg <= req;
        end
        if (s1_done)
        begin
            out_item_reg.parsed_address <= sum.addr;
            out_item_reg.parsed_port    <= sum.port;
            out_item_reg.status         <= sum.status;
            out_item_reg.verdict_valid  <= verdict_valid;
            out_item_reg.same_subnet    <= same_subnet;
        end
    end

endmodule
`default_nettype wire
